// ===== rtl/rmc_pkg.sv =====
// Shared constants, types and helpers of the radix-m converter.
`default_nettype none

package rmc_pkg;

   localparam int VALUE_W        = 32;  // signed input width
   localparam int MAG_W          = 31;  // magnitude bits after saturation
   localparam int DIGIT_W        = 6;   // one digit, 0..35
   localparam int RADIX_W        = 6;   // radix register width
   localparam int REQ_TDATA_W    = 32;
   localparam int RSP_TDATA_W    = 8;   // digit padded to a whole byte
   localparam int MAX_DIGITS_DEF = 32;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 6'd35;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   // Saturate a written radix into the supported range.
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = r;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/radix_m_converter.sv =====
// Top level of the radix-m converter: systolic digit cells and digit emitter.
`default_nettype none

// Usage
//   req_*  : one request carries a signed 32-bit value in req_tdata.
//   rsp_*  : one response per output digit, most significant first. rsp_tdata
//            holds the digit, rsp_tuser flags a negative input, rsp_tlast marks
//            the least significant digit. Zero gives the single digit 0.
//   csr_*  : write the radix (2..36, saturated) while the block is idle.
// Timing
//   The magnitude (31 bits, MSB first) shifts one bit per cycle into a row of
//   MAX_DIGITS digit cells; each cell doubles its digit, adds the carry of the
//   cell below and reduces by the radix. Carries are registered between cells,
//   so the bit wave crosses the row in a skewed pattern; once it has crossed,
//   one digit leaves per cycle while the output is not stalled. req_tready
//   rises again once the last digit sits in the output register.
// Reset
//   Synchronous, active high: back to idle, radix 10, no response pending.
// Stall
//   A stalled response holds in the output register and the emitter waits;
//   the last digit may wait there while the next request is already converting.

module radix_m_converter #(
   parameter int MAX_DIGITS = rmc_pkg::MAX_DIGITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request: [31:0] value
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rmc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response: [5:0] digit, [7:6] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rmc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // response: [0] negative
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   // radix register
   input  logic                             csr_wr_en,
   input  logic [rmc_pkg::RADIX_W-1:0]      csr_wr_data
);
   import rmc_pkg::*;

   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W  = $clog2(MAX_DIGITS);
   localparam int FEED_W = $clog2(MAG_W + 1);

   // control state
   state_type               state_ff, state_in;
   logic [RADIX_W-1:0]      radix_ff, radix_in;
   logic [FEED_W-1:0]       feed_ff, feed_in;
   logic [MAX_DIGITS-1:0]   val_ff, val_in;
   logic [MAX_DIGITS-1:0]   carry_ff, carry_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload
   logic                    neg_ff, neg_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [DIGIT_W-1:0]      digit_ff [MAX_DIGITS];
   logic [DIGIT_W-1:0]      digit_in [MAX_DIGITS];
   logic [DIGIT_W-1:0]      rsp_digit_ff, rsp_digit_in;
   logic                    rsp_neg_ff, rsp_neg_in;
   logic                    rsp_last_ff, rsp_last_in;

   // cell datapath
   logic                    feed_vld;
   logic [MAX_DIGITS-1:0]   cin;
   logic [MAX_DIGITS-1:0]   vin;
   logic [MAX_DIGITS-1:0]   ge;
   logic [DIGIT_W-1:0]      nd [MAX_DIGITS];
   logic [DIGIT_W:0]        dbl [MAX_DIGITS];

   logic [VALUE_W-1:0]      neg_val;
   logic [MAG_W-1:0]        req_mag;
   logic [CNT_W-1:0]        left_m1;

   // Saturated magnitude of the incoming value.
   assign neg_val = ~req_tdata + VALUE_W'(1);
   always_comb begin
      if (!req_tdata[VALUE_W-1]) begin
         req_mag = req_tdata[MAG_W-1:0];
      end else if (req_tdata[MAG_W-1:0] == '0) begin
         req_mag = '1;
      end else begin
         req_mag = neg_val[MAG_W-1:0];
      end
   end

   assign feed_vld = (state_ff == ST_CONV) && (feed_ff < FEED_W'(MAG_W));

   // Each cell: digit = 2*digit + carry_in, reduced by the radix once.
   always_comb begin
      for (int k = 0; k < MAX_DIGITS; k++) begin
         if (k == 0) begin
            cin[k] = mag_ff[MAG_W-1];
            vin[k] = feed_vld;
         end else begin
            cin[k] = carry_ff[k-1];
            vin[k] = val_ff[k-1];
         end
         dbl[k] = {digit_ff[k], cin[k]};
         ge[k]  = dbl[k] >= {1'b0, radix_ff};
         if (ge[k]) begin
            nd[k] = DIGIT_W'(dbl[k] - {1'b0, radix_ff});
         end else begin
            nd[k] = dbl[k][DIGIT_W-1:0];
         end
      end
   end

   assign left_m1 = left_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      radix_in     = radix_ff;
      feed_in      = feed_ff;
      val_in       = val_ff;
      carry_in     = carry_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      digit_in     = digit_ff;
      rsp_digit_in = rsp_digit_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;

      if (csr_wr_en) begin
         radix_in = clamp_radix(csr_wr_data);
      end

      // drop a response once it is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               neg_in   = req_tdata[VALUE_W-1];
               mag_in   = req_mag;
               feed_in  = '0;
               count_in = '0;
               val_in   = '0;
               carry_in = '0;
               for (int k = 0; k < MAX_DIGITS; k++) begin
                  digit_in[k] = '0;
               end
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (feed_vld) begin
               mag_in  = {mag_ff[MAG_W-2:0], 1'b0};
               feed_in = feed_ff + FEED_W'(1);
            end
            for (int k = 0; k < MAX_DIGITS; k++) begin
               val_in[k]   = vin[k];
               carry_in[k] = vin[k] & ge[k];
               if (vin[k]) begin
                  digit_in[k] = nd[k];
               end
            end
            // the first cell to see a carry becomes the new top digit
            if ((count_ff < CNT_W'(MAX_DIGITS)) && cin[count_ff[IDX_W-1:0]]
                && vin[count_ff[IDX_W-1:0]]) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (!feed_vld && (val_ff == '0)) begin
               left_in  = (count_ff == '0) ? CNT_W'(1) : count_ff;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = digit_ff[left_m1[IDX_W-1:0]];
               rsp_neg_in   = neg_ff;
               rsp_last_in  = (left_ff == CNT_W'(1));
               left_in      = left_m1;
               if (left_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         feed_ff      <= '0;
         val_ff       <= '0;
         carry_ff     <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         feed_ff      <= feed_in;
         val_ff       <= val_in;
         carry_ff     <= carry_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      digit_ff     <= digit_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_neg_ff   <= rsp_neg_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_digit_ff);
   assign rsp_tuser  = rsp_neg_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/rmc_checker.sv =====
// Port-level checker of the radix-m converter and its bind.
`default_nettype none

module rmc_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [rmc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tuser,
   input  logic                             rsp_tlast
);
   import rmc_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // digit in range, padding zero
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_TDATA_W-1:DIGIT_W] == '0)
         && (rsp_tdata[DIGIT_W-1:0] <= DIGIT_MAX))
      else $error("digit out of range");

   // busy while converting
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken during conversion");

   // digits of one number follow back to back with the same sign
   a_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid
         && (rsp_tuser == $past(rsp_tuser)))
      else $error("digit run broken");

endmodule

bind radix_m_converter rmc_checker u_rmc_checker (.*);

`default_nettype wire
